// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the sort engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on the cycle right after reset is seen.
`define QS_ASSERT_AFTER_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) rst |=> prop) \
      else $error(msg);

`endif

// ===== rtl/qs_pkg.sv =====
package qs_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_WIDTH   = $clog2(MAX_ITEMS);
   localparam int CNT_WIDTH   = $clog2(MAX_ITEMS + 1);
   // pending ranges hold two or more elements and never overlap
   localparam int STACK_DEPTH = (MAX_ITEMS / 2 < 2) ? 2 : MAX_ITEMS / 2;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);
   localparam int OP_WIDTH    = 5;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_WIDTH-1:0]         idx_type;
   typedef logic [CNT_WIDTH-1:0]         cnt_type;
   typedef logic [SP_WIDTH-1:0]          sp_type;
   typedef logic [STK_AW-1:0]            stk_addr_type;
   typedef logic [OP_WIDTH-1:0]          op_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   localparam op_type OP_NONE     = 5'd0;
   localparam op_type OP_LOAD     = 5'd1;
   localparam op_type OP_INIT     = 5'd2;
   localparam op_type OP_POP      = 5'd3;
   localparam op_type OP_POP_LOAD = 5'd4;
   localparam op_type OP_PIVOT    = 5'd5;
   localparam op_type OP_COUNT    = 5'd6;
   localparam op_type OP_SWP_RD   = 5'd7;
   localparam op_type OP_SWP_LO   = 5'd8;
   localparam op_type OP_SWP_PL   = 5'd9;
   localparam op_type OP_I_RD     = 5'd10;
   localparam op_type OP_I_CHK    = 5'd11;
   localparam op_type OP_J_RD     = 5'd12;
   localparam op_type OP_J_CHK    = 5'd13;
   localparam op_type OP_SWAP_J   = 5'd14;
   localparam op_type OP_PUSH_R   = 5'd15;
   localparam op_type OP_PUSH_L   = 5'd16;
   localparam op_type OP_EM_RD    = 5'd17;
   localparam op_type OP_EM_LOAD  = 5'd18;
   localparam op_type OP_EM_NEXT  = 5'd19;
   localparam op_type OP_CLEAR    = 5'd20;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic le;           // element read back is not greater than the pivot
      logic cnt_last;     // counting pass is at the top of the range
      logic i_done;       // left scan reached the pivot slot
      logic j_done;       // right scan reached the pivot slot
      logic stack_empty;
      logic few;          // fewer than two elements stored
      logic em_last;      // result register holds the final item
   } status_type;

endpackage

// ===== rtl/qs_ram.sv =====
module qs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/qs_ctrl.sv =====
`include "assert_macros.svh"

module qs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_item,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  qs_pkg::status_type status,
   output qs_pkg::cmd_type    cmd
);

   import qs_pkg::*;

   localparam logic [4:0] S_LOAD    = 5'd0;
   localparam logic [4:0] S_INIT    = 5'd1;
   localparam logic [4:0] S_POP     = 5'd2;
   localparam logic [4:0] S_POP_LD  = 5'd3;
   localparam logic [4:0] S_PIVOT   = 5'd4;
   localparam logic [4:0] S_CNT     = 5'd5;
   localparam logic [4:0] S_SWP_RD  = 5'd6;
   localparam logic [4:0] S_SWP_LO  = 5'd7;
   localparam logic [4:0] S_SWP_PL  = 5'd8;
   localparam logic [4:0] S_I_RD    = 5'd9;
   localparam logic [4:0] S_I_CHK   = 5'd10;
   localparam logic [4:0] S_J_RD    = 5'd11;
   localparam logic [4:0] S_J_CHK   = 5'd12;
   localparam logic [4:0] S_SWAP_J  = 5'd13;
   localparam logic [4:0] S_PUSH_R  = 5'd14;
   localparam logic [4:0] S_PUSH_L  = 5'd15;
   localparam logic [4:0] S_EM_RD   = 5'd16;
   localparam logic [4:0] S_EM_LD   = 5'd17;
   localparam logic [4:0] S_EM_WAIT = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (req_last_item) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = status.few ? S_EM_RD : S_POP;
         end
         S_POP: begin
            cmd.op   = OP_POP;
            state_in = status.stack_empty ? S_EM_RD : S_POP_LD;
         end
         S_POP_LD: begin
            cmd.op   = OP_POP_LOAD;
            state_in = S_PIVOT;
         end
         S_PIVOT: begin
            cmd.op   = OP_PIVOT;
            state_in = S_CNT;
         end
         S_CNT: begin
            cmd.op = OP_COUNT;
            if (status.cnt_last) begin
               state_in = S_SWP_RD;
            end
         end
         S_SWP_RD: begin
            cmd.op   = OP_SWP_RD;
            state_in = S_SWP_LO;
         end
         S_SWP_LO: begin
            cmd.op   = OP_SWP_LO;
            state_in = S_SWP_PL;
         end
         S_SWP_PL: begin
            cmd.op   = OP_SWP_PL;
            state_in = S_I_RD;
         end
         S_I_RD: begin
            if (status.i_done) begin
               state_in = S_PUSH_R;
            end else begin
               cmd.op   = OP_I_RD;
               state_in = S_I_CHK;
            end
         end
         S_I_CHK: begin
            cmd.op   = OP_I_CHK;
            state_in = status.le ? S_I_RD : S_J_RD;
         end
         S_J_RD: begin
            if (status.j_done) begin
               state_in = S_PUSH_R;
            end else begin
               cmd.op   = OP_J_RD;
               state_in = S_J_CHK;
            end
         end
         S_J_CHK: begin
            cmd.op   = OP_J_CHK;
            state_in = status.le ? S_SWAP_J : S_J_RD;
         end
         S_SWAP_J: begin
            cmd.op   = OP_SWAP_J;
            state_in = S_I_RD;
         end
         S_PUSH_R: begin
            cmd.op   = OP_PUSH_R;
            state_in = S_PUSH_L;
         end
         S_PUSH_L: begin
            cmd.op   = OP_PUSH_L;
            state_in = S_POP;
         end
         S_EM_RD: begin
            cmd.op   = OP_EM_RD;
            state_in = S_EM_LD;
         end
         S_EM_LD: begin
            cmd.op   = OP_EM_LOAD;
            state_in = S_EM_WAIT;
         end
         S_EM_WAIT: begin
            if (rsp_ready) begin
               if (status.em_last) begin
                  cmd.op   = OP_CLEAR;
                  state_in = S_LOAD;
               end else begin
                  cmd.op   = OP_EM_NEXT;
                  state_in = S_EM_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_EM_WAIT);

   `QS_ASSERT_AFTER_RESET(a_ready_after_reset, clock, reset, req_ready,
      "block not ready for items after reset")
   `QS_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid),
      "loading and emitting at the same time")
   `QS_ASSERT(a_last_closes, clock, reset,
      (req_valid && req_ready && req_last_item) |=> !req_ready,
      "item marked last did not close the set")
   `QS_ASSERT(a_reopen, clock, reset,
      (rsp_valid && rsp_ready && status.em_last) |=> req_ready,
      "block not reopened after the final result")

endmodule

// ===== rtl/qs_dpath.sv =====
`include "assert_macros.svh"

module qs_dpath (
   input  logic               clock,
   input  logic               reset,
   input  qs_pkg::cmd_type    cmd,
   output qs_pkg::status_type status,
   input  qs_pkg::data_type   req_value,
   output qs_pkg::data_type   rsp_sorted_value,
   output logic               rsp_last_result,
   output logic               rsp_overflowed
);

   import qs_pkg::*;

   cnt_type  count_ff, count_in;
   logic     ovf_ff, ovf_in;
   sp_type   sp_ff, sp_in;
   idx_type  lo_ff, lo_in;
   idx_type  hi_ff, hi_in;
   idx_type  k_ff, k_in;
   idx_type  i_ff, i_in;
   idx_type  j_ff, j_in;
   idx_type  place_ff, place_in;
   idx_type  cnt_ff, cnt_in;
   data_type pivot_ff, pivot_in;
   data_type tmp_ff, tmp_in;
   data_type rsp_value_ff, rsp_value_in;
   logic     rsp_last_ff, rsp_last_in;
   logic     rsp_ovf_ff, rsp_ovf_in;

   logic         e_we;
   idx_type      e_waddr;
   data_type     e_wdata;
   idx_type      e_raddr;
   data_type     e_rdata;
   logic         push_en;
   range_type    push_val;
   logic         s_we;
   stk_addr_type s_raddr;
   range_type    s_rdata;
   logic         le;

   qs_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(MAX_ITEMS)
   ) u_elem_ram (
      .clock  (clock),
      .wr_en  (e_we),
      .wr_addr(e_waddr),
      .wr_data(e_wdata),
      .rd_addr(e_raddr),
      .rd_data(e_rdata)
   );

   qs_ram #(
      .WIDTH($bits(range_type)),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(sp_ff[STK_AW-1:0]),
      .wr_data(push_val),
      .rd_addr(s_raddr),
      .rd_data(s_rdata)
   );

   assign le      = (e_rdata <= pivot_ff);
   assign s_raddr = STK_AW'(sp_ff - 1'b1);
   assign s_we    = push_en && (sp_ff < SP_WIDTH'(STACK_DEPTH));

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sp_in        = sp_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      place_in     = place_ff;
      cnt_in       = cnt_ff;
      pivot_in     = pivot_ff;
      tmp_in       = tmp_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      e_we         = 1'b0;
      e_waddr      = count_ff[IDX_WIDTH-1:0];
      e_wdata      = req_value;
      e_raddr      = i_ff;
      push_en      = 1'b0;
      push_val     = '{lo: place_ff + 1'b1, hi: hi_ff};
      case (cmd.op)
         OP_LOAD: begin
            // drop items once the buffer is full
            if (count_ff < CNT_WIDTH'(MAX_ITEMS)) begin
               e_we     = 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         OP_INIT: begin
            i_in     = '0;
            push_en  = !status.few;
            push_val = '{lo: '0, hi: IDX_WIDTH'(count_ff - 1'b1)};
            if (s_we) begin
               sp_in = sp_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (sp_ff == '0) begin
               i_in = '0;
            end else begin
               sp_in = sp_ff - 1'b1;
            end
         end
         OP_POP_LOAD: begin
            lo_in   = s_rdata.lo;
            hi_in   = s_rdata.hi;
            e_raddr = s_rdata.lo;
         end
         OP_PIVOT: begin
            pivot_in = e_rdata;
            cnt_in   = '0;
            k_in     = lo_ff + 1'b1;
            e_raddr  = lo_ff + 1'b1;
         end
         OP_COUNT: begin
            cnt_in   = cnt_ff + IDX_WIDTH'(le);
            place_in = lo_ff + cnt_in;
            k_in     = k_ff + 1'b1;
            e_raddr  = k_ff + 1'b1;
         end
         OP_SWP_RD: begin
            e_raddr = place_ff;
         end
         OP_SWP_LO: begin
            e_we    = 1'b1;
            e_waddr = lo_ff;
            e_wdata = e_rdata;
         end
         OP_SWP_PL: begin
            e_we    = 1'b1;
            e_waddr = place_ff;
            e_wdata = pivot_ff;
            i_in    = lo_ff;
            j_in    = hi_ff;
         end
         OP_I_RD: begin
            e_raddr = i_ff;
         end
         OP_I_CHK: begin
            // hold the misplaced left element for the swap
            if (le) begin
               i_in = i_ff + 1'b1;
            end else begin
               tmp_in = e_rdata;
            end
         end
         OP_J_RD: begin
            e_raddr = j_ff;
         end
         OP_J_CHK: begin
            if (le) begin
               e_we    = 1'b1;
               e_waddr = i_ff;
               e_wdata = e_rdata;
            end else begin
               j_in = j_ff - 1'b1;
            end
         end
         OP_SWAP_J: begin
            e_we    = 1'b1;
            e_waddr = j_ff;
            e_wdata = tmp_ff;
            i_in    = i_ff + 1'b1;
            j_in    = j_ff - 1'b1;
         end
         OP_PUSH_R: begin
            push_en  = ({1'b0, place_ff} + 1'b1) < {1'b0, hi_ff};
            push_val = '{lo: place_ff + 1'b1, hi: hi_ff};
            if (s_we) begin
               sp_in = sp_ff + 1'b1;
            end
         end
         OP_PUSH_L: begin
            push_en  = ({1'b0, lo_ff} + 1'b1) < {1'b0, place_ff};
            push_val = '{lo: lo_ff, hi: place_ff - 1'b1};
            if (s_we) begin
               sp_in = sp_ff + 1'b1;
            end
         end
         OP_EM_RD: begin
            e_raddr = i_ff;
         end
         OP_EM_LOAD: begin
            rsp_value_in = e_rdata;
            rsp_last_in  = (CNT_WIDTH'(i_ff) + 1'b1) == count_ff;
            rsp_ovf_in   = ovf_ff;
         end
         OP_EM_NEXT: begin
            i_in = i_ff + 1'b1;
         end
         OP_CLEAR: begin
            count_in = '0;
            ovf_in   = 1'b0;
            sp_in    = '0;
         end
         default: begin
            e_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      k_ff         <= k_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      place_ff     <= place_in;
      cnt_ff       <= cnt_in;
      pivot_ff     <= pivot_in;
      tmp_ff       <= tmp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign status.le          = le;
   assign status.cnt_last    = (k_ff == hi_ff);
   assign status.i_done      = (i_ff >= place_ff);
   assign status.j_done      = (j_ff <= place_ff);
   assign status.stack_empty = (sp_ff == '0);
   assign status.few         = (count_ff < CNT_WIDTH'(2));
   assign status.em_last     = rsp_last_ff;

   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   `QS_ASSERT(a_stack_bound, clock, reset, sp_ff <= SP_WIDTH'(STACK_DEPTH),
      "range stack pointer past its depth")
   `QS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_WIDTH'(MAX_ITEMS),
      "element count past capacity")
   `QS_ASSERT(a_left_scan, clock, reset, (cmd.op == OP_I_RD) |-> (i_ff < place_ff),
      "left scan reads at or past the pivot slot")

endmodule

// ===== rtl/quicksort_engine.sv =====
// Sorting engine for sets of up to MAX_ITEMS signed values. Items are taken one per
// cycle on the req_ channel; the item with req_last_item high closes the set, and items
// arriving with the buffer full are accepted but dropped, which sets rsp_overflowed on
// every result of that set. The buffer is then sorted in place by quicksort on a range
// stack held in a small RAM: each partition pass covers the pop, counting, pivot
// placement, the scans with their swaps and the two pushes, all paced by the single
// read port of the element RAM. Results come out in ascending order, with
// rsp_last_result on the greatest; each is read, registered and held until rsp_ready
// takes it, and only then is the next one read. No item is taken while a set is sorted
// or emitted. No clearing pass runs after reset.
module quicksort_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qs_pkg::data_type req_value,
   input  logic             req_last_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qs_pkg::data_type rsp_sorted_value,
   output logic             rsp_last_result,
   output logic             rsp_overflowed
);

   import qs_pkg::*;

   cmd_type    cmd;
   status_type status;

   qs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_item(req_last_item),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   qs_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_value),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_result (rsp_last_result),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule
